### design/csq_pkg.sv
// Shared types and constants for the counting semaphore unit with wait queues.
package csq_pkg;

   // Table geometry and fixed field widths.
   localparam int NUM_SEMS       = 4;
   localparam int SEM_BITS       = 2;
   localparam int INDEX_BITS     = 3;
   localparam int VALUE_BITS     = 16;
   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = 16;

   // Defaults for the top-level parameters.
   localparam int DEF_WAIT_DEPTH = 16;
   localparam int DEF_TID_BITS   = 16;

   // Register map: init values first, then maximum values.
   localparam int CSR_INIT_BASE = 0;
   localparam int CSR_MAX_BASE  = NUM_SEMS;
   localparam int CSR_COUNT     = 2 * NUM_SEMS;

   // Request kinds.
   typedef enum logic {
      REQ_WAIT   = 1'b0,
      REQ_SIGNAL = 1'b1
   } req_kind_type;

   // Result status codes.
   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_NO_SEM     = 2'd1,
      STATUS_AT_MAX     = 2'd2,
      STATUS_QUEUE_FULL = 2'd3
   } status_type;

endpackage

### design/csq_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module csq_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/counting_semaphore_wait_queues_unit.sv
// Top level of the counting semaphore unit: four semaphores with FIFO wait queues.
//
// Usage: a request (req_type wait or signal, req_sem_index, req_caller_tid)
// is taken on the req_ channel when req_valid is high and req_stall is low.
// Every request yields exactly one response on the rsp_ channel, in order,
// carrying a status, whether the caller was queued, and the thread released
// by a signal. A response is taken when rsp_valid is high and rsp_stall low.
// Path: an accepted request waits in the middle stage for the registered RAM
// read (the wait queues live in one RAM), then moves into the response register.
// Throughput: one request per cycle while req_stall is low. Counters and queue
// pointers are updated in the cycle a request is taken, so the next request sees
// them directly. When the receiver stalls, the response register and the one
// request behind it hold, and req_stall rises until the response is taken.
// The csr_ port writes init values (indices 0 to 3, which also empty that
// queue) and maximum values (indices 4 to 7); other indices are ignored. It is
// always ready. Write it only while no request is in flight; the block does not
// enforce this. Reset clears all counts and queues and sets every maximum to one;
// the queue RAM needs no clearing since only pushed entries are ever read.
module counting_semaphore_wait_queues_unit #(
   parameter int WAIT_DEPTH = csq_pkg::DEF_WAIT_DEPTH,
   parameter int TID_BITS   = csq_pkg::DEF_TID_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_type,
   input  logic [csq_pkg::INDEX_BITS-1:0]       req_sem_index,
   input  logic [TID_BITS-1:0]                  req_caller_tid,
   // Response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [1:0]                           rsp_status,
   output logic                                 rsp_caller_blocked,
   output logic                                 rsp_woken_valid,
   output logic [TID_BITS-1:0]                  rsp_woken_tid,
   // Configuration write channel
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [csq_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [csq_pkg::CSR_DATA_BITS-1:0]    csr_data
);

   import csq_pkg::*;

   localparam int PTR_BITS  = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
   localparam int FILL_BITS = $clog2(WAIT_DEPTH + 1);
   localparam int RAM_DEPTH = NUM_SEMS << PTR_BITS;
   localparam int ADDR_BITS = SEM_BITS + PTR_BITS;

   // Semaphore table registers.
   logic [VALUE_BITS-1:0] value_ff [NUM_SEMS];
   logic [VALUE_BITS-1:0] value_in [NUM_SEMS];
   logic [VALUE_BITS-1:0] max_ff   [NUM_SEMS];
   logic [VALUE_BITS-1:0] max_in   [NUM_SEMS];
   logic [PTR_BITS-1:0]   head_ff  [NUM_SEMS];
   logic [PTR_BITS-1:0]   head_in  [NUM_SEMS];
   logic [PTR_BITS-1:0]   tail_ff  [NUM_SEMS];
   logic [PTR_BITS-1:0]   tail_in  [NUM_SEMS];
   logic [FILL_BITS-1:0]  fill_ff  [NUM_SEMS];
   logic [FILL_BITS-1:0]  fill_in  [NUM_SEMS];

   // Middle stage, waiting for the RAM read, and the response register.
   logic       s1_valid_ff, s1_valid_in;
   status_type s1_status_ff, s1_status_in;
   logic       s1_blocked_ff, s1_blocked_in;
   logic       s1_woken_ff, s1_woken_in;
   logic       out_valid_ff, out_valid_in;
   status_type out_status_ff, out_status_in;
   logic       out_blocked_ff, out_blocked_in;
   logic       out_woken_ff, out_woken_in;
   logic [TID_BITS-1:0] out_tid_ff, out_tid_in;

   // Decode of the current request.
   logic                  accept;
   logic                  s1_move;
   logic                  csr_write;
   logic                  sem_ok;
   logic [SEM_BITS-1:0]   sem;
   logic [VALUE_BITS-1:0] cur_value;
   logic [VALUE_BITS-1:0] cur_max;
   logic [PTR_BITS-1:0]   cur_head;
   logic [PTR_BITS-1:0]   cur_tail;
   logic [FILL_BITS-1:0]  cur_fill;
   status_type            dec_status;
   logic                  dec_blocked;
   logic                  dec_woken;
   logic                  do_push;
   logic                  do_pop;
   logic                  do_dec;
   logic                  do_inc;
   logic [TID_BITS-1:0]   ram_rd_data;

   // Handshakes: the middle stage advances when the response register frees up.
   assign s1_move   = s1_valid_ff & (~out_valid_ff | ~rsp_stall);
   assign req_stall = s1_valid_ff & ~s1_move;
   assign accept    = req_valid & ~req_stall;
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;

   // Look up the addressed semaphore.
   assign sem_ok    = (req_sem_index < INDEX_BITS'(NUM_SEMS));
   assign sem       = req_sem_index[SEM_BITS-1:0];
   assign cur_value = value_ff[sem];
   assign cur_max   = max_ff[sem];
   assign cur_head  = head_ff[sem];
   assign cur_tail  = tail_ff[sem];
   assign cur_fill  = fill_ff[sem];

   // Decide what the request does to the addressed semaphore.
   always_comb begin
      dec_status  = STATUS_OK;
      dec_blocked = 1'b0;
      dec_woken   = 1'b0;
      do_push     = 1'b0;
      do_pop      = 1'b0;
      do_dec      = 1'b0;
      do_inc      = 1'b0;
      if (!sem_ok) begin
         dec_status = STATUS_NO_SEM;
      end else if (req_type == REQ_WAIT) begin
         if (cur_value == '0) begin
            if (cur_fill == FILL_BITS'(WAIT_DEPTH)) begin
               dec_status = STATUS_QUEUE_FULL;
            end else begin
               do_push     = 1'b1;
               dec_blocked = 1'b1;
            end
         end else begin
            do_dec = 1'b1;
         end
      end else begin
         if (cur_value >= cur_max) begin
            dec_status = STATUS_AT_MAX;
         end else if (cur_fill != '0) begin
            do_pop    = 1'b1;
            dec_woken = 1'b1;
         end else begin
            do_inc = 1'b1;
         end
      end
   end

   // Next state of the table: configuration writes, else the accepted request.
   always_comb begin
      value_in = value_ff;
      max_in   = max_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      fill_in  = fill_ff;
      if (csr_write) begin
         if (csr_index < CSR_INDEX_BITS'(CSR_MAX_BASE)) begin
            value_in[csr_index[SEM_BITS-1:0]] = VALUE_BITS'(csr_data);
            head_in[csr_index[SEM_BITS-1:0]]  = '0;
            tail_in[csr_index[SEM_BITS-1:0]]  = '0;
            fill_in[csr_index[SEM_BITS-1:0]]  = '0;
         end else if (csr_index < CSR_INDEX_BITS'(CSR_COUNT)) begin
            max_in[csr_index[SEM_BITS-1:0]] = VALUE_BITS'(csr_data);
         end
      end else if (accept) begin
         if (do_dec) begin
            value_in[sem] = cur_value - VALUE_BITS'(1);
         end
         if (do_inc) begin
            value_in[sem] = cur_value + VALUE_BITS'(1);
         end
         if (do_push) begin
            tail_in[sem] = (cur_tail == PTR_BITS'(WAIT_DEPTH - 1)) ? '0
                                                                  : cur_tail + PTR_BITS'(1);
            fill_in[sem] = cur_fill + FILL_BITS'(1);
         end
         if (do_pop) begin
            head_in[sem] = (cur_head == PTR_BITS'(WAIT_DEPTH - 1)) ? '0
                                                                  : cur_head + PTR_BITS'(1);
            fill_in[sem] = cur_fill - FILL_BITS'(1);
         end
      end
   end

   // Wait queue storage: pushes write at the tail, pops read at the head.
   csq_ram #(
      .WIDTH (TID_BITS),
      .DEPTH (RAM_DEPTH)
   ) u_wait_ram (
      .clock   (clock),
      .wr_en   (accept & do_push),
      .wr_addr (ADDR_BITS'({sem, cur_tail})),
      .wr_data (req_caller_tid),
      .rd_en   (accept & do_pop),
      .rd_addr (ADDR_BITS'({sem, cur_head})),
      .rd_data (ram_rd_data)
   );

   // Pipeline control for the middle stage and the response register.
   always_comb begin
      s1_valid_in    = s1_valid_ff;
      s1_status_in   = s1_status_ff;
      s1_blocked_in  = s1_blocked_ff;
      s1_woken_in    = s1_woken_ff;
      out_valid_in   = out_valid_ff;
      out_status_in  = out_status_ff;
      out_blocked_in = out_blocked_ff;
      out_woken_in   = out_woken_ff;
      out_tid_in     = out_tid_ff;
      if (accept) begin
         s1_valid_in   = 1'b1;
         s1_status_in  = dec_status;
         s1_blocked_in = dec_blocked;
         s1_woken_in   = dec_woken;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
      if (s1_move) begin
         out_valid_in   = 1'b1;
         out_status_in  = s1_status_ff;
         out_blocked_in = s1_blocked_ff;
         out_woken_in   = s1_woken_ff;
         out_tid_in     = s1_woken_ff ? ram_rd_data : '0;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   // Control and payload registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int s = 0; s < NUM_SEMS; s++) begin
            value_ff[s] <= '0;
            max_ff[s]   <= VALUE_BITS'(1);
            head_ff[s]  <= '0;
            tail_ff[s]  <= '0;
            fill_ff[s]  <= '0;
         end
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         value_ff     <= value_in;
         max_ff       <= max_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         fill_ff      <= fill_in;
      end
      s1_status_ff   <= s1_status_in;
      s1_blocked_ff  <= s1_blocked_in;
      s1_woken_ff    <= s1_woken_in;
      out_status_ff  <= out_status_in;
      out_blocked_ff <= out_blocked_in;
      out_woken_ff   <= out_woken_in;
      out_tid_ff     <= out_tid_in;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_status         = out_status_ff;
   assign rsp_caller_blocked = out_blocked_ff;
   assign rsp_woken_valid    = out_woken_ff;
   assign rsp_woken_tid      = out_tid_ff;

   // A queued caller or a released waiter always comes with an ok status.
   a_flags_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_caller_blocked || rsp_woken_valid) |-> rsp_status == STATUS_OK)
      else $error("blocked or woken response without ok status");

   // A response never both queues the caller and releases a waiter.
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_caller_blocked && rsp_woken_valid))
      else $error("response both blocked and woken");

   // A stalled middle stage keeps new requests out.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && out_valid_ff && rsp_stall |-> !accept)
      else $error("request accepted over a held stage");

   // A pop is only issued on a non-empty queue.
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      accept && do_pop |-> cur_fill != '0 && cur_fill <= FILL_BITS'(WAIT_DEPTH))
      else $error("pop from an empty queue");

   // The queue fill of the addressed semaphore never exceeds the depth.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      sem_ok |-> cur_fill <= FILL_BITS'(WAIT_DEPTH))
      else $error("queue fill beyond depth");

endmodule
